[hdl/ccmsc_pkg.sv]
// ccmsc_pkg: request codes, datapath operation codes and the status bundle
// shared by the cons cell collector controller and datapath. No dependencies.
package ccmsc_pkg;

   localparam logic [1:0] REQ_WRITE_CELL = 2'd0;
   localparam logic [1:0] REQ_WRITE_ROOT = 2'd1;
   localparam logic [1:0] REQ_READ_CELL  = 2'd2;
   localparam logic [1:0] REQ_COLLECT    = 2'd3;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_INIT,
      OP_LOAD,
      OP_WCELL,
      OP_WROOT,
      OP_RESP_READ,
      OP_MSET,
      OP_ROOT_RD,
      OP_ROOT_EV,
      OP_WALK_RD,
      OP_WALK_EV,
      OP_POP,
      OP_POP_EV,
      OP_SWP_RD,
      OP_SWP_EV,
      OP_SWP_LINK,
      OP_FIN
   } dp_op_type;

   typedef struct packed {
      logic root_pos;
      logic cur_ok;
      logic mark_set;
      logic sp_zero;
      logic init_last;
      logic node_last;
      logic root_last;
   } dp_status_type;

endpackage

[hdl/ccmsc_datapath.sv]
// ccmsc_datapath: cell, mark, root and stack memories, walk and sweep registers,
// response registers. Executes one operation code per cycle. Uses ccmsc_pkg.
module ccmsc_datapath #(
   parameter int NODE_COUNT  = 256,
   parameter int ROOT_SLOTS  = 256,
   parameter int STACK_DEPTH = 256
) (
   input  logic                      clock,
   input  logic                      reset,
   input  ccmsc_pkg::dp_op_type      op,
   output ccmsc_pkg::dp_status_type  status,
   input  logic [7:0]                req_node_index,
   input  logic [7:0]                req_slot_index,
   input  logic signed [8:0]         req_left_value,
   input  logic signed [8:0]         req_right_value,
   input  logic signed [8:0]         req_link_value,
   output logic                      rsp_strobe,
   output logic signed [8:0]         rsp_cell_left,
   output logic signed [8:0]         rsp_cell_right,
   output logic                      rsp_cell_garbage,
   output logic [7:0]                rsp_free_head,
   output logic                      rsp_stack_overflow
);

   localparam int NW    = $clog2(NODE_COUNT);
   localparam int RTW   = $clog2(ROOT_SLOTS);
   localparam int SW    = $clog2(STACK_DEPTH);
   localparam int SPW   = SW + 1;
   localparam int IW    = (NW > RTW) ? NW : RTW;
   localparam int MAXNR = (NODE_COUNT > ROOT_SLOTS) ? NODE_COUNT : ROOT_SLOTS;
   localparam int VW    = (NW + 2 > 9) ? NW + 2 : 9;

   logic signed [8:0]    left_mem  [NODE_COUNT];
   logic signed [VW-1:0] right_mem [NODE_COUNT];
   logic                 mark_mem  [NODE_COUNT];
   logic signed [8:0]    root_mem  [ROOT_SLOTS];
   logic signed [VW-1:0] stack_mem [STACK_DEPTH];

   logic signed [8:0]    left_q;
   logic signed [VW-1:0] right_q;
   logic                 mark_q;
   logic signed [8:0]    root_q;
   logic signed [VW-1:0] stack_q;

   logic [IW-1:0]        idx_ff, idx_in;
   logic signed [VW-1:0] cur_ff, cur_in;
   logic [SPW-1:0]       sp_ff, sp_in, spm1;
   logic [NW-1:0]        prev_ff, prev_in, head_ff, head_in;
   logic                 ovf_ff, ovf_in;
   logic [7:0]           node_ff, slot_ff;
   logic signed [8:0]    left_ff, right_ff, link_ff;

   logic                 strobe_ff, strobe_in;
   logic signed [8:0]    out_left_ff, out_left_in, out_right_ff, out_right_in;
   logic                 out_gb_ff, out_gb_in, out_ovf_ff, out_ovf_in;
   logic [7:0]           out_head_ff, out_head_in;

   logic                 left_we, right_we, mark_we, root_we, stack_we;
   logic [NW-1:0]        left_wa, right_wa, mark_wa, node_ra;
   logic signed [8:0]    left_wd, root_wd;
   logic signed [VW-1:0] right_wd, stack_wd;
   logic                 mark_wd;
   logic [RTW-1:0]       root_wa;
   logic [SW-1:0]        stack_wa, stack_ra;
   logic                 node_re, root_re, stack_re;
   logic                 node_ok, slot_ok, idx_in_nodes, idx_in_roots, cur_ok;

   assign node_ok      = 32'(node_ff) < NODE_COUNT;
   assign slot_ok      = 32'(slot_ff) < ROOT_SLOTS;
   assign idx_in_nodes = 32'(idx_ff) < NODE_COUNT;
   assign idx_in_roots = 32'(idx_ff) < ROOT_SLOTS;
   assign cur_ok       = (cur_ff > 0) && (cur_ff < $signed(VW'(NODE_COUNT)));
   assign spm1         = sp_ff - SPW'(1);

   assign status.root_pos  = root_q > 0;
   assign status.cur_ok    = cur_ok;
   assign status.mark_set  = mark_q;
   assign status.sp_zero   = sp_ff == '0;
   assign status.init_last = idx_ff == IW'(MAXNR - 1);
   assign status.node_last = idx_ff == IW'(NODE_COUNT - 1);
   assign status.root_last = idx_ff == IW'(ROOT_SLOTS - 1);

   always_comb begin
      left_we = 1'b0; left_wa = '0; left_wd = '0;
      right_we = 1'b0; right_wa = '0; right_wd = '0;
      mark_we = 1'b0; mark_wa = '0; mark_wd = 1'b0;
      root_we = 1'b0; root_wa = '0; root_wd = '0;
      stack_we = 1'b0; stack_wa = '0; stack_wd = '0;
      node_re = 1'b0; node_ra = '0;
      root_re = 1'b0; stack_re = 1'b0; stack_ra = '0;
      idx_in = idx_ff; cur_in = cur_ff; sp_in = sp_ff;
      prev_in = prev_ff; head_in = head_ff; ovf_in = ovf_ff;
      strobe_in = 1'b0;
      out_left_in = '0; out_right_in = '0; out_gb_in = 1'b0;
      out_head_in = '0; out_ovf_in = 1'b0;
      unique case (op)
         ccmsc_pkg::OP_INIT: begin
            left_we  = idx_in_nodes;
            left_wa  = idx_ff[NW-1:0];
            right_we = idx_in_nodes;
            right_wa = idx_ff[NW-1:0];
            right_wd = (idx_ff == '0 || idx_ff == IW'(NODE_COUNT - 1)) ? '0
                       : VW'(idx_ff) + VW'(1);
            mark_we  = idx_in_nodes;
            mark_wa  = idx_ff[NW-1:0];
            mark_wd  = 1'b1;
            root_we  = idx_in_roots;
            root_wa  = idx_ff[RTW-1:0];
            idx_in   = status.init_last ? '0 : idx_ff + IW'(1);
         end
         ccmsc_pkg::OP_LOAD: begin
            node_re = 1'b1;
            node_ra = NW'(req_node_index);
            idx_in  = '0;
            prev_in = '0;
            head_in = '0;
            ovf_in  = 1'b0;
         end
         ccmsc_pkg::OP_WCELL: begin
            left_we   = node_ok;
            left_wa   = NW'(node_ff);
            left_wd   = left_ff;
            right_we  = node_ok;
            right_wa  = NW'(node_ff);
            right_wd  = VW'(right_ff);
            strobe_in = 1'b1;
         end
         ccmsc_pkg::OP_WROOT: begin
            root_we   = slot_ok;
            root_wa   = RTW'(slot_ff);
            root_wd   = link_ff;
            strobe_in = 1'b1;
         end
         ccmsc_pkg::OP_RESP_READ: begin
            strobe_in = 1'b1;
            if (node_ok) begin
               out_left_in  = left_q;
               out_right_in = right_q[8:0];
               out_gb_in    = mark_q;
            end
         end
         ccmsc_pkg::OP_MSET: begin
            mark_we = 1'b1;
            mark_wa = idx_ff[NW-1:0];
            mark_wd = 1'b1;
            idx_in  = status.node_last ? '0 : idx_ff + IW'(1);
         end
         ccmsc_pkg::OP_ROOT_RD: begin
            root_re = 1'b1;
         end
         ccmsc_pkg::OP_ROOT_EV: begin
            if (status.root_pos) begin
               cur_in = VW'(root_q);
               sp_in  = '0;
            end else begin
               idx_in = status.root_last ? IW'(1) : idx_ff + IW'(1);
            end
         end
         ccmsc_pkg::OP_WALK_RD: begin
            node_re = cur_ok;
            node_ra = cur_ff[NW-1:0];
         end
         ccmsc_pkg::OP_WALK_EV: begin
            if (mark_q) begin
               mark_we = 1'b1;
               mark_wa = cur_ff[NW-1:0];
               mark_wd = 1'b0;
               if (left_q > 0) begin
                  if (right_q > 0) begin
                     if (sp_ff < SPW'(STACK_DEPTH)) begin
                        stack_we = 1'b1;
                        stack_wa = sp_ff[SW-1:0];
                        stack_wd = right_q;
                        sp_in    = sp_ff + SPW'(1);
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  cur_in = VW'(left_q);
               end else begin
                  cur_in = right_q;
               end
            end
         end
         ccmsc_pkg::OP_POP: begin
            if (sp_ff != '0) begin
               sp_in    = spm1;
               stack_re = 1'b1;
               stack_ra = spm1[SW-1:0];
            end else begin
               idx_in = status.root_last ? IW'(1) : idx_ff + IW'(1);
            end
         end
         ccmsc_pkg::OP_POP_EV: begin
            cur_in = stack_q;
         end
         ccmsc_pkg::OP_SWP_RD: begin
            node_re = 1'b1;
            node_ra = idx_ff[NW-1:0];
         end
         ccmsc_pkg::OP_SWP_EV: begin
            if (mark_q) begin
               left_we  = 1'b1;
               left_wa  = idx_ff[NW-1:0];
               right_we = 1'b1;
               right_wa = idx_ff[NW-1:0];
               if (head_ff == '0) begin
                  head_in = idx_ff[NW-1:0];
               end
            end else begin
               idx_in = idx_ff + IW'(1);
            end
         end
         ccmsc_pkg::OP_SWP_LINK: begin
            right_we = 1'b1;
            right_wa = prev_ff;
            right_wd = VW'(idx_ff);
            prev_in  = idx_ff[NW-1:0];
            idx_in   = idx_ff + IW'(1);
         end
         ccmsc_pkg::OP_FIN: begin
            left_we     = 1'b1;
            right_we    = 1'b1;
            strobe_in   = 1'b1;
            out_head_in = 8'(head_ff);
            out_ovf_in  = ovf_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (left_we) begin
         left_mem[left_wa] <= left_wd;
      end
      if (right_we) begin
         right_mem[right_wa] <= right_wd;
      end
      if (node_re) begin
         left_q  <= left_mem[node_ra];
         right_q <= right_mem[node_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (mark_we) begin
         mark_mem[mark_wa] <= mark_wd;
      end
      if (node_re) begin
         mark_q <= mark_mem[node_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (root_we) begin
         root_mem[root_wa] <= root_wd;
      end
      if (root_re) begin
         root_q <= root_mem[idx_ff[RTW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (stack_we) begin
         stack_mem[stack_wa] <= stack_wd;
      end
      if (stack_re) begin
         stack_q <= stack_mem[stack_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff    <= '0;
         sp_ff     <= '0;
         ovf_ff    <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         idx_ff    <= idx_in;
         sp_ff     <= sp_in;
         ovf_ff    <= ovf_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      prev_ff      <= prev_in;
      head_ff      <= head_in;
      out_left_ff  <= out_left_in;
      out_right_ff <= out_right_in;
      out_gb_ff    <= out_gb_in;
      out_head_ff  <= out_head_in;
      out_ovf_ff   <= out_ovf_in;
      if (op == ccmsc_pkg::OP_LOAD) begin
         node_ff  <= req_node_index;
         slot_ff  <= req_slot_index;
         left_ff  <= req_left_value;
         right_ff <= req_right_value;
         link_ff  <= req_link_value;
      end
   end

   assign rsp_strobe         = strobe_ff;
   assign rsp_cell_left      = out_left_ff;
   assign rsp_cell_right     = out_right_ff;
   assign rsp_cell_garbage   = out_gb_ff;
   assign rsp_free_head      = out_head_ff;
   assign rsp_stack_overflow = out_ovf_ff;

   a_sp_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SPW'(STACK_DEPTH))
      else $error("mark stack pointer beyond depth");

   a_ovf_src: assert property (@(posedge clock) disable iff (reset)
      $rose(ovf_ff) |-> $past(op) == ccmsc_pkg::OP_WALK_EV)
      else $error("overflow flag set outside a walk step");

endmodule

[hdl/ccmsc_ctrl.sv]
// ccmsc_ctrl: one-hot sequencer for init pass, requests, marking and sweeping.
// Drives one datapath operation per cycle. Uses ccmsc_pkg.
module ccmsc_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [1:0]                req_type,
   input  ccmsc_pkg::dp_status_type  status,
   output ccmsc_pkg::dp_op_type      op,
   output logic                      busy
);

   typedef enum logic [15:0] {
      S_INIT    = 16'h0001,
      S_IDLE    = 16'h0002,
      S_WCELL   = 16'h0004,
      S_WROOT   = 16'h0008,
      S_READ    = 16'h0010,
      S_MSET    = 16'h0020,
      S_ROOTRD  = 16'h0040,
      S_ROOTEV  = 16'h0080,
      S_WALKRD  = 16'h0100,
      S_WALKEV  = 16'h0200,
      S_POP     = 16'h0400,
      S_POPEV   = 16'h0800,
      S_SWPRD   = 16'h1000,
      S_SWPEV   = 16'h2000,
      S_SWPLINK = 16'h4000,
      S_FIN     = 16'h8000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      op       = ccmsc_pkg::OP_NONE;
      unique case (state_ff)
         S_INIT: begin
            op = ccmsc_pkg::OP_INIT;
            if (status.init_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               op = ccmsc_pkg::OP_LOAD;
               unique case (req_type)
                  ccmsc_pkg::REQ_WRITE_CELL: state_in = S_WCELL;
                  ccmsc_pkg::REQ_WRITE_ROOT: state_in = S_WROOT;
                  ccmsc_pkg::REQ_READ_CELL:  state_in = S_READ;
                  ccmsc_pkg::REQ_COLLECT:    state_in = S_MSET;
                  default:                   state_in = S_IDLE;
               endcase
            end
         end
         S_WCELL: begin
            op = ccmsc_pkg::OP_WCELL;
            state_in = S_IDLE;
         end
         S_WROOT: begin
            op = ccmsc_pkg::OP_WROOT;
            state_in = S_IDLE;
         end
         S_READ: begin
            op = ccmsc_pkg::OP_RESP_READ;
            state_in = S_IDLE;
         end
         S_MSET: begin
            op = ccmsc_pkg::OP_MSET;
            if (status.node_last) state_in = S_ROOTRD;
         end
         S_ROOTRD: begin
            op = ccmsc_pkg::OP_ROOT_RD;
            state_in = S_ROOTEV;
         end
         S_ROOTEV: begin
            op = ccmsc_pkg::OP_ROOT_EV;
            priority if (status.root_pos) state_in = S_WALKRD;
            else if (status.root_last) state_in = S_SWPRD;
            else state_in = S_ROOTRD;
         end
         S_WALKRD: begin
            op = ccmsc_pkg::OP_WALK_RD;
            state_in = status.cur_ok ? S_WALKEV : S_POP;
         end
         S_WALKEV: begin
            op = ccmsc_pkg::OP_WALK_EV;
            state_in = status.mark_set ? S_WALKRD : S_POP;
         end
         S_POP: begin
            op = ccmsc_pkg::OP_POP;
            priority if (!status.sp_zero) state_in = S_POPEV;
            else if (status.root_last) state_in = S_SWPRD;
            else state_in = S_ROOTRD;
         end
         S_POPEV: begin
            op = ccmsc_pkg::OP_POP_EV;
            state_in = S_WALKRD;
         end
         S_SWPRD: begin
            op = ccmsc_pkg::OP_SWP_RD;
            state_in = S_SWPEV;
         end
         S_SWPEV: begin
            op = ccmsc_pkg::OP_SWP_EV;
            priority if (status.mark_set) state_in = S_SWPLINK;
            else if (status.node_last) state_in = S_FIN;
            else state_in = S_SWPRD;
         end
         S_SWPLINK: begin
            op = ccmsc_pkg::OP_SWP_LINK;
            state_in = status.node_last ? S_FIN : S_SWPRD;
         end
         S_FIN: begin
            op = ccmsc_pkg::OP_FIN;
            state_in = S_IDLE;
         end
         default: state_in = S_INIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = state_ff != S_IDLE;

   a_accept: assert property (@(posedge clock) disable iff (reset)
      start && state_ff == S_IDLE |=> state_ff != S_IDLE)
      else $error("accepted item did not leave idle");

   a_walk_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WALKEV |-> $past(state_ff) == S_WALKRD)
      else $error("walk step without cell read");

endmodule

[hdl/cons_cell_mark_sweep_collector.sv]
// cons_cell_mark_sweep_collector: top level of the mark and sweep cons cell
// collector. Instantiates ccmsc_ctrl and ccmsc_datapath; uses ccmsc_pkg.
//
// Usage: drive req_* and raise start; an item is taken on an edge where
// start is high and busy is low. Every item gives exactly one result, shown
// on rsp_* for one cycle with rsp_strobe high; the receiver cannot stall.
// Cell write, root write and cell read: the controller passes through
// S_WCELL, S_WROOT or S_READ and back to idle; the result is strobed in
// the cycle in which busy is low again, so the next item can then be taken.
// Collect: all marks are set; each root slot is read and evaluated, and a
// positive root starts a walk that reads and evaluates each cell entered,
// pushing right links and popping them at path ends; the sweep reads and
// evaluates each cell index, links each freed cell, then finishes.
// The walk is bound by the single read port of the cell memories.
// Reset: synchronous; afterwards a clearing pass over every cell and root
// slot index loads cell, mark and root reset values while busy is high and
// no item is taken.
module cons_cell_mark_sweep_collector #(
   parameter int NODE_COUNT  = 256,
   parameter int ROOT_SLOTS  = 256,
   parameter int STACK_DEPTH = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_type,
   input  logic [7:0]        req_node_index,
   input  logic [7:0]        req_slot_index,
   input  logic signed [8:0] req_left_value,
   input  logic signed [8:0] req_right_value,
   input  logic signed [8:0] req_link_value,
   output logic              rsp_strobe,
   output logic signed [8:0] rsp_cell_left,
   output logic signed [8:0] rsp_cell_right,
   output logic              rsp_cell_garbage,
   output logic [7:0]        rsp_free_head,
   output logic              rsp_stack_overflow
);

   ccmsc_pkg::dp_op_type     op;
   ccmsc_pkg::dp_status_type status;

   ccmsc_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_type (req_type),
      .status   (status),
      .op       (op),
      .busy     (busy)
   );

   ccmsc_datapath #(
      .NODE_COUNT  (NODE_COUNT),
      .ROOT_SLOTS  (ROOT_SLOTS),
      .STACK_DEPTH (STACK_DEPTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .op                 (op),
      .status             (status),
      .req_node_index     (req_node_index),
      .req_slot_index     (req_slot_index),
      .req_left_value     (req_left_value),
      .req_right_value    (req_right_value),
      .req_link_value     (req_link_value),
      .rsp_strobe         (rsp_strobe),
      .rsp_cell_left      (rsp_cell_left),
      .rsp_cell_right     (rsp_cell_right),
      .rsp_cell_garbage   (rsp_cell_garbage),
      .rsp_free_head      (rsp_free_head),
      .rsp_stack_overflow (rsp_stack_overflow)
   );

endmodule

[tb/tb_cons_cell_mark_sweep_collector.sv]
// Testbench for cons_cell_mark_sweep_collector: directed and random cell,
// root, read and collect items are checked against an in-bench mark and
// sweep predictor. Depends on ccmsc_pkg and the collector top level.
`timescale 1ns / 100ps

module tb_cons_cell_mark_sweep_collector;

   localparam int NODES = 256;
   localparam int SLOTS = 256;
   localparam int DEPTH = 256;
   localparam longint CYCLE_LIMIT = 64'd3000000;

   typedef struct {
      logic [1:0]        kind;
      logic [7:0]        node;
      logic [7:0]        slot;
      logic signed [8:0] left;
      logic signed [8:0] right;
      logic signed [8:0] link;
   } cmd_type;

   typedef struct {
      logic signed [8:0] left;
      logic signed [8:0] right;
      logic              garbage;
      logic [7:0]        head;
      logic              overflow;
   } reply_type;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic [1:0] req_type = '0;
   logic [7:0] req_node_index = '0;
   logic [7:0] req_slot_index = '0;
   logic signed [8:0] req_left_value = '0;
   logic signed [8:0] req_right_value = '0;
   logic signed [8:0] req_link_value = '0;
   logic rsp_strobe;
   logic signed [8:0] rsp_cell_left;
   logic signed [8:0] rsp_cell_right;
   logic rsp_cell_garbage;
   logic [7:0] rsp_free_head;
   logic rsp_stack_overflow;

   cons_cell_mark_sweep_collector dut (.*);

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   // predictor state
   int cell_l[NODES];
   int cell_r[NODES];
   bit mark[NODES];
   int roots[SLOTS];
   int walk_stack[DEPTH];
   bit spilled;

   cmd_type   pending[$];
   reply_type awaited[$];
   int     errors = 0;
   int     collects = 0;
   int     reads = 0;
   int     spills = 0;
   int     offered = 0;
   int     taken = 0;
   longint cycles = 0;
   bit     quiet = 0;
   bit     hold = 0;

   function automatic int sx9(logic [8:0] v);
      return $signed(v);
   endfunction

   function automatic void heap_reset();
      for (int i = 0; i < NODES; i++) begin
         cell_l[i] = 0;
         cell_r[i] = i + 1;
         mark[i] = 1;
      end
      cell_r[0] = 0;
      cell_r[NODES-1] = 0;
      for (int i = 0; i < SLOTS; i++) roots[i] = 0;
   endfunction

   function automatic void trace_from(int origin);
      int cur;
      int sp;
      int l;
      int r;
      cur = origin;
      sp = 0;
      forever begin
         if (cur <= 0 || cur >= NODES || !mark[cur]) begin
            if (sp == 0) break;
            sp--;
            cur = walk_stack[sp];
            continue;
         end
         mark[cur] = 0;
         l = cell_l[cur];
         r = cell_r[cur];
         if (l > 0) begin
            if (r > 0) begin
               if (sp < DEPTH) begin
                  walk_stack[sp] = r;
                  sp++;
               end else spilled = 1;
            end
            cur = l;
         end else cur = r;
      end
   endfunction

   function automatic reply_type apply_cmd(cmd_type c);
      reply_type o;
      int head;
      int prev;
      o = '{left: '0, right: '0, garbage: 0, head: '0, overflow: 0};
      case (c.kind)
         ccmsc_pkg::REQ_WRITE_CELL: begin
            cell_l[c.node] = sx9(c.left);
            cell_r[c.node] = sx9(c.right);
         end
         ccmsc_pkg::REQ_WRITE_ROOT: roots[c.slot] = sx9(c.link);
         ccmsc_pkg::REQ_READ_CELL: begin
            o.left = cell_l[c.node][8:0];
            o.right = cell_r[c.node][8:0];
            o.garbage = mark[c.node];
         end
         default: begin
            spilled = 0;
            head = 0;
            prev = 0;
            for (int i = 0; i < NODES; i++) mark[i] = 1;
            for (int i = 0; i < SLOTS; i++)
               if (roots[i] > 0) trace_from(roots[i]);
            for (int i = 1; i < NODES; i++) begin
               if (mark[i]) begin
                  cell_l[i] = 0;
                  cell_r[i] = 0;
                  cell_r[prev] = i;
                  prev = i;
                  if (head == 0) head = i;
               end
            end
            cell_l[0] = 0;
            cell_r[0] = 0;
            o.head = head[7:0];
            o.overflow = spilled;
         end
      endcase
      return o;
   endfunction

   function automatic int rand_val();
      case ($urandom_range(0, 5))
         0: return 0;
         1: return -$urandom_range(1, 255);
         2: return 255;
         3: return -255;
         default: return $urandom_range(1, 255);
      endcase
   endfunction

   function automatic void add(logic [1:0] k, int n, int s, int l, int r, int lk);
      cmd_type c;
      c.kind = k;
      c.node = n[7:0];
      c.slot = s[7:0];
      c.left = l[8:0];
      c.right = r[8:0];
      c.link = lk[8:0];
      pending.push_back(c);
   endfunction

   // driver: an offered item stays in place until it is taken
   always @(negedge clock) begin
      if (reset) begin
         start <= 0;
      end else if (!start || taken == offered) begin
         if (!hold && pending.size() > 0
             && (quiet || $urandom_range(0, 99) >= 23)) begin
            req_type <= pending[0].kind;
            req_node_index <= pending[0].node;
            req_slot_index <= pending[0].slot;
            req_left_value <= pending[0].left;
            req_right_value <= pending[0].right;
            req_link_value <= pending[0].link;
            start <= 1;
            offered++;
         end else begin
            start <= 0;
         end
      end
   end

   always @(posedge clock) begin
      cmd_type c;
      if (!reset && start && !busy) begin
         c.kind = req_type;
         c.node = req_node_index;
         c.slot = req_slot_index;
         c.left = req_left_value;
         c.right = req_right_value;
         c.link = req_link_value;
         awaited.push_back(apply_cmd(c));
         if (c.kind == ccmsc_pkg::REQ_COLLECT) collects++;
         if (c.kind == ccmsc_pkg::REQ_READ_CELL) reads++;
         void'(pending.pop_front());
         taken++;
      end
   end

   // monitor
   always @(posedge clock) begin
      reply_type e;
      cycles++;
      if (!reset && rsp_strobe) begin
         if (awaited.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result at cycle %0d", cycles);
         end else begin
            e = awaited.pop_front();
            if (e.overflow) spills++;
            if (rsp_cell_left !== e.left || rsp_cell_right !== e.right
                || rsp_cell_garbage !== e.garbage || rsp_free_head !== e.head
                || rsp_stack_overflow !== e.overflow) begin
               errors++;
               if (errors <= 10)
                  $display({"mismatch: exp l=%0d r=%0d g=%0d h=%0d o=%0d",
                            " got l=%0d r=%0d g=%0d h=%0d o=%0d"},
                           e.left, e.right, e.garbage, e.head, e.overflow,
                           rsp_cell_left, rsp_cell_right, rsp_cell_garbage,
                           rsp_free_head, rsp_stack_overflow);
            end
         end
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("FAIL cons_cell_mark_sweep_collector");
         $finish;
      end
   end

   initial begin
      int n;
      int k;
      heap_reset();
      repeat (6) @(posedge clock);
      @(negedge clock) reset = 0;

      // directed
      add(ccmsc_pkg::REQ_READ_CELL, 0, 0, 0, 0, 0);
      add(ccmsc_pkg::REQ_READ_CELL, 255, 0, 0, 0, 0);
      add(ccmsc_pkg::REQ_COLLECT, 0, 0, 0, 0, 0);
      add(ccmsc_pkg::REQ_WRITE_CELL, 1, 0, 2, 3, 0);
      add(ccmsc_pkg::REQ_WRITE_CELL, 2, 0, -255, 1, 0);
      add(ccmsc_pkg::REQ_WRITE_CELL, 3, 0, 255, 0, 0);
      add(ccmsc_pkg::REQ_WRITE_CELL, 255, 0, -1, -255, 0);
      add(ccmsc_pkg::REQ_WRITE_CELL, 0, 0, 255, 255, 0);
      add(ccmsc_pkg::REQ_WRITE_ROOT, 0, 0, 0, 0, 1);
      add(ccmsc_pkg::REQ_WRITE_ROOT, 0, 255, 0, 0, -255);
      add(ccmsc_pkg::REQ_WRITE_ROOT, 0, 7, 0, 0, 255);
      add(ccmsc_pkg::REQ_READ_CELL, 1, 0, 0, 0, 0);
      add(ccmsc_pkg::REQ_COLLECT, 0, 0, 0, 0, 0);
      add(ccmsc_pkg::REQ_READ_CELL, 0, 0, 0, 0, 0);
      add(ccmsc_pkg::REQ_READ_CELL, 2, 0, 0, 0, 0);
      add(ccmsc_pkg::REQ_READ_CELL, 4, 0, 0, 0, 0);
      // every root live and every cell reachable: nothing free
      for (int i = 1; i < 256; i++) add(ccmsc_pkg::REQ_WRITE_ROOT, 0, i, 0, 0, i);
      add(ccmsc_pkg::REQ_COLLECT, 0, 0, 0, 0, 0);
      // left spine with right siblings pushes 254 entries, within the stack depth
      for (int i = 1; i < 255; i++)
         add(ccmsc_pkg::REQ_WRITE_CELL, i, 0, i + 1, 255, 0);
      for (int i = 1; i < 256; i++) add(ccmsc_pkg::REQ_WRITE_ROOT, 0, i, 0, 0, 0);
      add(ccmsc_pkg::REQ_COLLECT, 0, 0, 0, 0, 0);
      add(ccmsc_pkg::REQ_READ_CELL, 200, 0, 0, 0, 0);

      // quiet stretch and drain
      quiet = 1;
      wait (pending.size() == 0);
      hold = 1;
      wait (awaited.size() == 0);
      hold = 0;
      quiet = 0;

      // random: small structures over cells 1 to 40, then collect and probe; or mixed random items
      n = 0;
      while (n < 770) begin
         if ($urandom_range(0, 9) < 8) begin
            k = $urandom_range(4, 20);
            for (int j = 0; j < k; j++) begin
               int a;
               a = $urandom_range(1, 40);
               add(ccmsc_pkg::REQ_WRITE_CELL, a, 0,
                   $urandom_range(0, 2) ? $urandom_range(0, 40) : rand_val(),
                   $urandom_range(0, 2) ? $urandom_range(0, 40) : rand_val(), 0);
            end
            for (int j = 0; j < 3; j++)
               add(ccmsc_pkg::REQ_WRITE_ROOT, 0, $urandom_range(0, 255), 0, 0,
                   $urandom_range(0, 1) ? $urandom_range(1, 40) : rand_val());
            add(ccmsc_pkg::REQ_COLLECT, 0, 0, 0, 0, 0);
            for (int j = 0; j < 4; j++)
               add(ccmsc_pkg::REQ_READ_CELL, $urandom_range(0, 45), 0, 0, 0, 0);
            n += k + 8;
         end else begin
            k = $urandom_range(5, 15);
            for (int j = 0; j < k; j++)
               add(2'($urandom_range(0, 3)), $urandom_range(0, 255),
                   $urandom_range(0, 255), rand_val(), rand_val(), rand_val());
            n += k;
         end
         if (n > 350 && n < 410) quiet = 1;
         else quiet = 0;
         wait (pending.size() < 40);
      end

      wait (pending.size() == 0);
      wait (awaited.size() == 0);
      repeat (20) @(posedge clock);
      $display("ran %0d collections and %0d cell reads; %0d collections overflowed the stack",
               collects, reads, spills);
      if (errors == 0) $display("PASS cons_cell_mark_sweep_collector");
      else begin
         $display("%0d mismatches", errors);
         $display("FAIL cons_cell_mark_sweep_collector");
      end
      $finish;
   end
endmodule
